/* rtl/core/rsm_pkg.sv */
// ----------------------------------------------------------------------------
// rsm_pkg
// shared types and constants for the tcp stream reassembler
// ----------------------------------------------------------------------------
package rsm_pkg;

  localparam int unsigned CFG_W   = 7;   // window capacity register width
  localparam int unsigned OCC_W   = 7;   // occupancy and pending counters
  localparam int unsigned CAP_MAX = 64;  // capacity ceiling in bytes

  typedef enum logic [1:0] {
    OP_SEGMENT = 2'd0,
    OP_EOF     = 2'd1,
    OP_CONSUME = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [31:0]         stream_index;
    logic [7:0]          data_byte;
    logic                segment_end;
    logic                eof_flag;
    logic [OCC_W-1:0]    consume_count;
  } in_word_t;

  typedef struct packed {
    logic                byte_valid;
    logic [7:0]          out_byte;
    logic                last_of_run;
    logic [OCC_W-1:0]    pending_count;
    logic                stream_ended;
  } out_word_t;

endpackage

/* rtl/core/rsm_ram.sv */
// ----------------------------------------------------------------------------
// rsm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/tcp_stream_reassembler.sv */
// ----------------------------------------------------------------------------
// tcp_stream_reassembler
// flow: an accepted word is executed, then the valid map is walked one entry
//   per cycle; a word with no assembled byte gives one status result, and each
//   byte of a run is read from the ring, loaded and held until taken; a new
//   word is accepted only when the last result of the previous one is taken
// reset: rst_n synchronous active low clears control and the valid map at
//   once; the byte ring is not cleared and no clearing pass runs
// ----------------------------------------------------------------------------
module tcp_stream_reassembler #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input words
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rsm_pkg::in_word_t            in_data,
  // result words
  output logic                         out_valid,
  input  logic                         out_ready,
  output rsm_pkg::out_word_t           out_data,
  // window capacity register
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rsm_pkg::CFG_W-1:0]    cfg_data
);

  import rsm_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);      // ring slot width
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);  // run length width

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a word
    S_EXEC,   // apply opcode: window check and ring write
    S_SCAN,   // walk the contiguous run one slot per cycle
    S_READ,   // issue ring read for the next run byte
    S_LOAD,   // capture ring data into the output register
    S_OUT     // hold result until taken
  } state_t;

  state_t            state_r, state_nxt;
  in_word_t          in_r, in_nxt;
  logic [31:0]       ne_r, ne_nxt;             // next expected stream index
  logic [AW-1:0]     ne_slot_r, ne_slot_nxt;   // next expected index mod depth
  logic [OCC_W-1:0]  occ_r, occ_nxt;           // output buffer occupancy
  logic [OCC_W-1:0]  total_r, total_nxt;       // bytes held, not assembled
  logic              eof_r, eof_nxt;
  logic [CFG_W-1:0]  wcap_r, wcap_nxt;
  logic [RING_DEPTH-1:0] valid_r, valid_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;           // run length found by the scan
  logic [CW-1:0]     left_r, left_nxt;         // run bytes still to emit
  logic [AW-1:0]     rd_slot_r, rd_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r, out_nxt;

  // window arithmetic
  logic [CFG_W-1:0]  cap;
  logic [OCC_W-1:0]  room;
  logic [OCC_W-1:0]  win;
  logic [31:0]       idx_gap;
  logic              in_win;
  logic [AW:0]       slot_sum;
  logic [AW-1:0]     ins_slot;
  logic              scan_go;

  // ring port
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [7:0]        ram_rd_data;

  rsm_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ins_slot),
    .wr_data (in_r.data_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_slot_r),
    .rd_data (ram_rd_data)
  );

  // capacity clamps to the ceiling, room saturates at zero, window to ring size
  assign cap  = (wcap_r > CFG_W'(CAP_MAX)) ? CFG_W'(CAP_MAX) : wcap_r;
  assign room = (cap > occ_r) ? (cap - occ_r) : '0;
  assign win  = (room > OCC_W'(RING_DEPTH)) ? OCC_W'(RING_DEPTH) : room;

  // distance wraps mod 2^32, so indexes below next expected fall outside
  assign idx_gap = in_r.stream_index - ne_r;
  assign in_win  = idx_gap < 32'(win);

  // idx_gap < depth here, so one conditional subtract gives the slot
  assign slot_sum = {1'b0, ne_slot_r} + idx_gap[AW:0];
  assign ins_slot = (slot_sum >= (AW+1)'(RING_DEPTH)) ?
                    AW'(slot_sum - (AW+1)'(RING_DEPTH)) : slot_sum[AW-1:0];

  // run continues while below ring depth, the slot holds a byte and the output has room
  assign scan_go = (cnt_r < CW'(RING_DEPTH)) && (occ_r < cap) && valid_r[ne_slot_r];

  assign ram_wr_en = (state_r == S_EXEC) && (in_r.opcode == OP_SEGMENT) && in_win;
  assign ram_rd_en = (state_r == S_READ);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    ne_nxt        = ne_r;
    ne_slot_nxt   = ne_slot_r;
    occ_nxt       = occ_r;
    total_nxt     = total_r;
    eof_nxt       = eof_r;
    wcap_nxt      = wcap_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    rd_slot_nxt   = rd_slot_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (cfg_valid) begin
      wcap_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (in_r.opcode)
          OP_SEGMENT: begin
            if (in_win) begin
              if (!valid_r[ins_slot]) begin
                valid_nxt[ins_slot] = 1'b1;
                total_nxt           = total_r + OCC_W'(1);
              end
              // eof only counts when the segment's last byte fit
              if (in_r.segment_end && in_r.eof_flag) begin
                eof_nxt = 1'b1;
              end
            end
          end
          OP_EOF: begin
            if (in_r.eof_flag) begin
              eof_nxt = 1'b1;
            end
          end
          OP_CONSUME: begin
            occ_nxt = (in_r.consume_count > occ_r) ? '0 : (occ_r - in_r.consume_count);
          end
          default: begin
          end
        endcase
        cnt_nxt     = '0;
        rd_slot_nxt = ne_slot_r;
        state_nxt   = S_SCAN;
      end

      S_SCAN: begin
        if (scan_go) begin
          // assemble this byte: release slot and advance the stream
          valid_nxt[ne_slot_r] = 1'b0;
          ne_nxt               = ne_r + 32'd1;
          ne_slot_nxt          = (ne_slot_r == AW'(RING_DEPTH - 1)) ? '0 : ne_slot_r + AW'(1);
          occ_nxt              = occ_r + OCC_W'(1);
          total_nxt            = (total_r != '0) ? total_r - OCC_W'(1) : '0;
          cnt_nxt              = cnt_r + CW'(1);
        end else if (cnt_r == '0) begin
          // nothing assembled: a single status word
          out_nxt.byte_valid    = 1'b0;
          out_nxt.out_byte      = '0;
          out_nxt.last_of_run   = 1'b1;
          out_nxt.pending_count = total_r;
          out_nxt.stream_ended  = eof_r && (total_r == '0);
          out_valid_nxt         = 1'b1;
          state_nxt             = S_OUT;
        end else begin
          left_nxt  = cnt_r;
          state_nxt = S_READ;
        end
      end

      S_READ: begin
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        out_nxt.byte_valid    = 1'b1;
        out_nxt.out_byte      = ram_rd_data;
        out_nxt.last_of_run   = (left_r == CW'(1));
        out_nxt.pending_count = total_r;
        out_nxt.stream_ended  = eof_r && (total_r == '0);
        out_valid_nxt         = 1'b1;
        state_nxt             = S_OUT;
      end

      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_of_run) begin
            state_nxt = S_IDLE;
          end else begin
            left_nxt    = left_r - CW'(1);
            rd_slot_nxt = (rd_slot_r == AW'(RING_DEPTH - 1)) ? '0 : rd_slot_r + AW'(1);
            state_nxt   = S_READ;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ne_r        <= '0;
      ne_slot_r   <= '0;
      occ_r       <= '0;
      total_r     <= '0;
      eof_r       <= 1'b0;
      wcap_r      <= CFG_W'(CAP_MAX);
      valid_r     <= '0;
      cnt_r       <= '0;
      left_r      <= '0;
      rd_slot_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ne_r        <= ne_nxt;
      ne_slot_r   <= ne_slot_nxt;
      occ_r       <= occ_nxt;
      total_r     <= total_nxt;
      eof_r       <= eof_nxt;
      wcap_r      <= wcap_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      left_r      <= left_nxt;
      rd_slot_r   <= rd_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  // held byte count tracks the valid map exactly
  a_total_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(total_r))
    else $error("pending count differs from valid map population");

  // draining never pushes occupancy past the capacity ceiling
  a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAP_MAX))
    else $error("output occupancy above capacity ceiling");

  // a result is only presented while holding for the consumer
  a_out_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT))
    else $error("result valid outside output hold");

  // an accepted word is executed on the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted word not executed");
`endif

endmodule

/* tb/sv/tb_tcp_stream_reassembler.sv */
// ----------------------------------------------------------------------------
// tb_tcp_stream_reassembler
// self-checking bench for the byte-serial stream reassembler: a local model
// tracks the ring, valid map, window and counters and queues the result
// words every accepted input word must cause; a monitor pops and compares
// them field by field while both channels idle at random
// ----------------------------------------------------------------------------
module tb_tcp_stream_reassembler;
  import rsm_pkg::*;

  localparam int unsigned RING_N         = 64;
  localparam int unsigned SETTLE_CYCLES  = 16;       // quiet cycles before cfg
  localparam int unsigned LONG_HOLD      = 300;      // receiver hold-off
  localparam int unsigned TIMEOUT_CYCLES = 1000000;
  localparam int unsigned SHOW_LIMIT     = 10;       // mismatches printed

  // clock and reset
  logic clk = 1'b0;
  logic rst_n;

  // input word channel
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;

  // result word channel
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // window capacity register
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  tcp_stream_reassembler #(
    .RING_DEPTH (RING_N)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // local copy of the reassembly state
  // --------------------------------------------------------------------------
  logic [7:0]       byte_store [RING_N];
  logic             held [RING_N];
  logic [31:0]      next_idx;
  int unsigned      out_fill;        // bytes sitting in the output buffer
  int unsigned      held_count;      // stored but not yet assembled
  logic             eof_mark;
  logic [CFG_W-1:0] cap_reg;

  out_word_t   due_results [$];      // result words still to arrive
  int unsigned fail_count = 0;

  // sender pacing
  int unsigned burst_left = 0;
  bit          steady_send = 1'b0;   // no gaps while set

  // receiver pacing
  logic [31:0] rx_cycle = '0;
  logic [7:0]  stall_pat = 8'hFF;
  logic        hold_req = 1'b0;      // toggled by the test to start a hold
  logic        hold_ack = 1'b0;
  int unsigned hold_left = 0;

  // effective capacity minus what the output buffer already holds
  function automatic int unsigned window_room();
    int unsigned cap;
    cap = (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;
    return (cap > out_fill) ? cap - out_fill : 0;
  endfunction

  // apply one input word to the local state and queue its result words
  function automatic void assemble_word(input in_word_t w);
    int unsigned cap;
    int unsigned win;
    int unsigned slot;
    int unsigned n;
    logic [31:0] idx_gap;
    logic [7:0]  run [RING_N];
    out_word_t   r;
    cap = (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;
    n = 0;
    case (w.opcode)
      OP_SEGMENT: begin
        win = window_room();
        if (win > RING_N) win = RING_N;
        // distance wraps mod 2^32, so anything behind next_idx is far away
        idx_gap = w.stream_index - next_idx;
        if (idx_gap < win) begin
          slot = w.stream_index % RING_N;
          if (!held[slot]) begin
            held[slot] = 1'b1;
            held_count++;
          end
          byte_store[slot] = w.data_byte;
          if (w.segment_end && w.eof_flag) eof_mark = 1'b1;
        end
      end
      OP_EOF: begin
        if (w.eof_flag) eof_mark = 1'b1;
      end
      OP_CONSUME: begin
        out_fill = (w.consume_count > out_fill) ? 0 : out_fill - w.consume_count;
      end
      default: ;
    endcase
    // drain the contiguous run, bounded by the ring and the capacity
    while (n < RING_N && out_fill < cap && held[next_idx % RING_N]) begin
      slot = next_idx % RING_N;
      run[n] = byte_store[slot];
      n++;
      held[slot] = 1'b0;
      next_idx++;
      out_fill++;
      if (held_count > 0) held_count--;
    end
    r.pending_count = held_count[OCC_W-1:0];
    r.stream_ended  = eof_mark && (held_count == 0);
    if (n == 0) begin
      // status only
      r.byte_valid  = 1'b0;
      r.out_byte    = '0;
      r.last_of_run = 1'b1;
      due_results.push_back(r);
    end else begin
      for (int k = 0; k < n; k++) begin
        r.byte_valid  = 1'b1;
        r.out_byte    = run[k];
        r.last_of_run = (k == n - 1);
        due_results.push_back(r);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // result monitor: values sampled at the edge are the pre-edge ones
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("%0t: unexpected result valid=%0d byte=%02h last=%0d pend=%0d ended=%0d",
                   $realtime, out_data.byte_valid, out_data.out_byte,
                   out_data.last_of_run, out_data.pending_count, out_data.stream_ended);
      end else begin
        e = due_results[0];
        due_results.delete(0);
        if (out_data.byte_valid !== e.byte_valid || out_data.out_byte !== e.out_byte ||
            out_data.last_of_run !== e.last_of_run ||
            out_data.pending_count !== e.pending_count ||
            out_data.stream_ended !== e.stream_ended) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display({"%0t: mismatch exp valid=%0d byte=%02h last=%0d pend=%0d ended=%0d",
                      " / got valid=%0d byte=%02h last=%0d pend=%0d ended=%0d"},
                     $realtime, e.byte_valid, e.out_byte, e.last_of_run,
                     e.pending_count, e.stream_ended,
                     out_data.byte_valid, out_data.out_byte, out_data.last_of_run,
                     out_data.pending_count, out_data.stream_ended);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: an 8-bit ready pattern indexed by rx_cycle[2:0], redrawn when rx_cycle[6:0]
  // is zero, overridden by a long hold whenever the test toggles hold_req
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[6:0] == 7'd0)
      stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= stall_pat[rx_cycle[2:0]];
    end
  end

  // hard stop
  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("tcp_stream_reassembler test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // word of the given opcode with every other field random
  function automatic in_word_t rand_word(input opcode_t op);
    in_word_t w;
    w.opcode        = op;
    w.stream_index  = $urandom;
    w.data_byte     = 8'($urandom);
    w.segment_end   = 1'($urandom);
    w.eof_flag      = ($urandom_range(0, 7) == 0);
    w.consume_count = 7'($urandom_range(0, 64));
    return w;
  endfunction

  // offer one word, bursts and gaps unless steady_send is set
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (!steady_send) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 6);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    assemble_word(w);
  endtask

  task automatic send_seg(input logic [31:0] idx, input logic [7:0] data,
                          input logic seg_end, input logic eof);
    in_word_t w;
    w = rand_word(OP_SEGMENT);
    w.stream_index = idx;
    w.data_byte    = data;
    w.segment_end  = seg_end;
    w.eof_flag     = eof;
    send_word(w);
  endtask

  task automatic send_consume(input int unsigned count);
    in_word_t w;
    w = rand_word(OP_CONSUME);
    w.consume_count = 7'(count);
    send_word(w);
  endtask

  // stop offering, wait for every result word, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = value;
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_in_order();
    write_capacity(7'd64);
    send_seg(32'd0, 8'h00, 1'b0, 1'b0);
    send_seg(32'd1, 8'hFF, 1'b0, 1'b0);
    send_seg(32'd2, 8'hA5, 1'b1, 1'b0);
  endtask

  // later bytes wait in the ring until the gap is filled
  task automatic test_out_of_order();
    logic [31:0] base;
    base = next_idx;
    send_seg(base + 2, 8'($urandom), 1'b1, 1'b0);
    send_seg(base + 1, 8'($urandom), 1'b0, 1'b0);
    send_seg(base,     8'($urandom), 1'b0, 1'b0);
  endtask

  // a byte already held is overwritten and not counted twice
  task automatic test_duplicate();
    logic [31:0] base;
    base = next_idx;
    send_seg(base + 1, 8'h3C, 1'b1, 1'b0);
    send_seg(base + 1, 8'hC3, 1'b1, 1'b0);
    send_seg(base,     8'h5A, 1'b0, 1'b0);
  endtask

  // over-consume saturates, then probe both window edges and far indices
  task automatic test_window_edges();
    logic [31:0] base;
    send_consume(64);
    send_consume(0);
    base = next_idx;
    send_seg(base + 64,           8'($urandom), 1'b1, 1'b0);  // just outside
    send_seg(base - 1,            8'($urandom), 1'b1, 1'b0);  // behind
    send_seg(base + 32'h8000_0000, 8'($urandom), 1'b1, 1'b0); // far away
    send_seg(base + 63,           8'($urandom), 1'b1, 1'b0);  // last slot in
  endtask

  task automatic test_nop();
    send_word(rand_word(OP_NOP));
  endtask

  // zero capacity takes nothing; a value above the ceiling acts as 64
  task automatic test_capacity_zero();
    write_capacity(7'd0);
    send_seg(next_idx, 8'($urandom), 1'b1, 1'b0);
    write_capacity(7'd127);
    send_consume(64);
    send_seg(next_idx, 8'($urandom), 1'b1, 1'b0);
  endtask

  // lowering capacity stops the drain, the rest stays pending
  task automatic test_capacity_lowered();
    logic [31:0] base;
    write_capacity(7'd64);
    send_consume(64);
    base = next_idx;
    send_seg(base + 1, 8'($urandom), 1'b0, 1'b0);
    send_seg(base + 2, 8'($urandom), 1'b0, 1'b0);
    send_seg(base + 3, 8'($urandom), 1'b1, 1'b0);
    write_capacity(7'd2);
    send_seg(base, 8'($urandom), 1'b0, 1'b0);
    send_consume(1);
  endtask

  // eof only counts on an accepted last byte or an empty eof segment
  task automatic test_eof();
    in_word_t w;
    write_capacity(7'd64);
    send_consume(64);
    send_seg(next_idx + 1, 8'($urandom), 1'b0, 1'b1);  // not segment end
    send_seg(next_idx - 1, 8'($urandom), 1'b1, 1'b1);  // dropped byte
    w = rand_word(OP_EOF);                             // empty, no marker
    w.eof_flag = 1'b0;
    send_word(w);
    send_seg(next_idx + 2, 8'($urandom), 1'b1, 1'b1);  // counts
    send_seg(next_idx,     8'($urandom), 1'b0, 1'b0);
    w = rand_word(OP_EOF);
    w.eof_flag = 1'b1;
    send_word(w);
  endtask

  // mostly well-formed segments near the window with random content,
  // plus consumes to keep room, and some noise
  task automatic test_random_traffic(input logic [CFG_W-1:0] cap_value,
                                     input int unsigned n_items);
    int unsigned done;
    int unsigned kind;
    int unsigned room;
    int unsigned len;
    int unsigned off;
    int unsigned shape;
    int unsigned tmp;
    int          j;
    int unsigned offs [8];
    logic [31:0] start;
    in_word_t    w;
    write_capacity(cap_value);
    done = 0;
    while (done < n_items) begin
      kind = $urandom_range(0, 99);
      room = window_room();
      if (room == 0 && kind < 60) kind = 70;   // window closed: make room
      if (kind < 60) begin
        len   = $urandom_range(1, 8);
        off   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, room - 1);
        start = next_idx + off;
        shape = $urandom_range(0, 2);
        for (int k = 0; k < len; k++) offs[k] = (shape == 1) ? len - 1 - k : k;
        if (shape == 2) begin
          for (int k = len - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = offs[k];
            offs[k] = offs[j];
            offs[j] = tmp;
          end
        end
        for (int k = 0; k < len; k++) begin
          w = rand_word(OP_SEGMENT);
          w.stream_index = start + offs[k];
          w.segment_end  = (offs[k] == len - 1);
          send_word(w);
        end
        done += len;
      end else if (kind < 80) begin
        send_consume(($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : out_fill);
        done++;
      end else if (kind < 88) begin
        send_word(rand_word(OP_SEGMENT));         // index anywhere
        done++;
      end else if (kind < 93) begin
        send_word(rand_word(OP_EOF));
        done++;
      end else if (kind < 96) begin
        send_word(rand_word(OP_NOP));
        done++;
      end else begin
        send_seg(next_idx - $urandom_range(1, 40), 8'($urandom), 1'($urandom), 1'($urandom));
        done++;
      end
    end
  endtask

  // fill the whole window out of order, then the head byte drains it all
  task automatic test_full_window_run();
    logic [31:0] base;
    int unsigned offs [RING_N - 1];
    int unsigned tmp;
    int          j;
    write_capacity(7'd127);
    send_consume(64);
    base = next_idx;
    for (int k = 0; k < RING_N - 1; k++) offs[k] = k + 1;
    for (int k = RING_N - 2; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = offs[k];
      offs[k] = offs[j];
      offs[j] = tmp;
    end
    for (int k = 0; k < RING_N - 1; k++)
      send_seg(base + offs[k], 8'($urandom), 1'($urandom), 1'b0);
    send_seg(base, 8'($urandom), 1'b0, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering, block must stall
  task automatic test_backpressure();
    write_capacity(7'd64);
    send_consume(64);
    steady_send = 1'b1;
    hold_req <= ~hold_req;
    for (int k = 0; k < 12; k++)
      send_seg(next_idx, 8'($urandom), 1'($urandom), 1'b0);
    steady_send = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    // model state after reset
    for (int k = 0; k < RING_N; k++) begin
      byte_store[k] = '0;
      held[k]       = 1'b0;
    end
    next_idx   = '0;
    out_fill   = 0;
    held_count = 0;
    eof_mark   = 1'b0;
    cap_reg    = 7'd64;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_in_order();
    test_out_of_order();
    test_duplicate();
    test_window_edges();
    test_nop();
    test_capacity_zero();
    test_capacity_lowered();
    test_eof();
    test_random_traffic(7'd64, 6);
    test_random_traffic(7'd1, 3);
    test_random_traffic(7'd20, 6);
    test_full_window_run();
    test_random_traffic(7'd127, 5);
    test_backpressure();
    test_random_traffic(7'($urandom_range(1, 64)), 4);

    settle();
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("tcp_stream_reassembler test passed");
    end else begin
      $display("tcp_stream_reassembler test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/rsm_pkg.sv
rtl/core/rsm_ram.sv
rtl/core/tcp_stream_reassembler.sv
tb/sv/tb_tcp_stream_reassembler.sv
